>>> design/pvs_pkg.sv
package pvs_pkg;

   // default configuration of the store
   localparam int PALETTE_DEPTH_DEF = 256;
   localparam int VALUE_BITS_DEF    = 16;
   localparam int HEIGHT_DEF        = 256;
   localparam int SIDE_DEF          = 16;

   // request and response field widths
   localparam int X_BITS           = 4;
   localparam int Y_BITS           = 8;
   localparam int Z_BITS           = 4;
   localparam int VALUE_FIELD_BITS = 16;
   localparam int USED_BITS        = 9;

   // request commands
   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   // response status codes
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   // controller to datapath commands
   typedef struct packed {
      logic clear;        // clear one cell per cycle after reset
      logic capture;      // latch an incoming request
      logic cell_rd;      // read the addressed cell index
      logic pal_rd_cell;  // read the palette at the cell index
      logic rsp_read;     // issue a read response
      logic scan_init;    // restart the palette scan
      logic scan;         // advance the palette scan
      logic commit;       // update cell and palette, issue a write response
   } dp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic clear_done;
      logic is_write;
      logic in_range;
      logic scan_hit;
      logic scan_miss;
   } dp_stat_type;

endpackage

>>> design/pvs_ctrl.sv
module pvs_ctrl
   import pvs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [6:0] {
      S_CLEAR  = 7'b0000001,
      S_IDLE   = 7'b0000010,
      S_DECIDE = 7'b0000100,
      S_RD_PAL = 7'b0001000,
      S_RD_OUT = 7'b0010000,
      S_SEARCH = 7'b0100000,
      S_COMMIT = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // sequence each request through the datapath
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (!stat.in_range) begin
               cmd.rsp_read = 1'b1;
               state_in     = S_IDLE;
            end else if (!stat.is_write) begin
               cmd.cell_rd = 1'b1;
               state_in    = S_RD_PAL;
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = S_SEARCH;
            end
         end
         S_RD_PAL: begin
            cmd.pal_rd_cell = 1'b1;
            state_in        = S_RD_OUT;
         end
         S_RD_OUT: begin
            cmd.rsp_read = 1'b1;
            state_in     = S_IDLE;
         end
         S_SEARCH: begin
            cmd.scan = 1'b1;
            if (stat.scan_hit || stat.scan_miss) state_in = S_COMMIT;
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

`ifndef SYNTHESIS
   // a request is taken only from idle, and always moves on to decode
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && start) |=> (state_ff == S_DECIDE))
      else $error("accepted request did not reach decode");

   // the scan ends only through a hit or a miss
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COMMIT) |-> ($past(state_ff) == S_SEARCH &&
                                  ($past(stat.scan_hit) || $past(stat.scan_miss))))
      else $error("commit without a finished palette scan");

   // once cleared, the store never returns to the clearing pass
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_CLEAR) |=> (state_ff != S_CLEAR))
      else $error("clearing pass re-entered without reset");
`endif

endmodule

>>> design/pvs_datapath.sv
module pvs_datapath
   import pvs_pkg::*;
#(
   parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF,
   parameter int VALUE_BITS    = VALUE_BITS_DEF,
   parameter int HEIGHT        = HEIGHT_DEF,
   parameter int SIDE          = SIDE_DEF
)
(
   input  logic                        clock,
   input  logic                        reset,
   input  dp_cmd_type                  cmd,
   output dp_stat_type                 stat,
   input  logic                        req_command,
   input  logic [X_BITS-1:0]           req_pos_x,
   input  logic [Y_BITS-1:0]           req_pos_y,
   input  logic [Z_BITS-1:0]           req_pos_z,
   input  logic [VALUE_FIELD_BITS-1:0] req_block_value,
   output logic                        rsp_strobe,
   output logic [VALUE_FIELD_BITS-1:0] rsp_read_value,
   output logic                        rsp_status,
   output logic [USED_BITS-1:0]        rsp_palette_used
);

   localparam int CELL_COUNT = SIDE * HEIGHT * SIDE;
   localparam int CELL_ABITS = $clog2(CELL_COUNT);
   localparam int IDX_BITS   = $clog2(PALETTE_DEPTH);
   localparam int CNT_BITS   = $clog2(PALETTE_DEPTH + 1);
   localparam int VW         = (VALUE_BITS < VALUE_FIELD_BITS) ? VALUE_BITS : VALUE_FIELD_BITS;

   // storage
   logic [IDX_BITS-1:0] cell_mem [CELL_COUNT];
   logic [VW-1:0]       pal_mem  [PALETTE_DEPTH];

   // request registers
   logic                  cmd_ff,      cmd_in;
   logic [CELL_ABITS-1:0] row_ff,      row_in;
   logic [Z_BITS-1:0]     z_ff,        z_in;
   logic [VW-1:0]         val_ff,      val_in;
   logic                  in_range_ff, in_range_in;

   // memory read data
   logic [IDX_BITS-1:0]   cell_q_ff;
   logic [VW-1:0]         pal_q_ff;

   // scan and bookkeeping
   logic [CNT_BITS-1:0]   scan_ff,     scan_in;
   logic                  rd_valid_ff, rd_valid_in;
   logic [IDX_BITS-1:0]   rd_idx_ff,   rd_idx_in;
   logic                  found_ff,    found_in;
   logic [IDX_BITS-1:0]   hit_idx_ff,  hit_idx_in;
   logic [CNT_BITS-1:0]   count_ff,    count_in;
   logic [CELL_ABITS-1:0] clr_ff,      clr_in;

   // response registers
   logic                        rsp_strobe_ff, rsp_strobe_in;
   logic [VALUE_FIELD_BITS-1:0] rsp_value_ff,  rsp_value_in;
   logic                        rsp_status_ff, rsp_status_in;
   logic [USED_BITS-1:0]        rsp_used_ff,   rsp_used_in;

   logic [CELL_ABITS-1:0] cell_addr;
   logic                  pal_full;
   logic                  scan_rd;
   logic                  commit_new;
   logic                  cell_we;
   logic [CELL_ABITS-1:0] cell_waddr;
   logic [IDX_BITS-1:0]   cell_wdata;
   logic                  pal_we;
   logic [IDX_BITS-1:0]   pal_waddr;
   logic [VW-1:0]         pal_wdata;
   logic                  pal_re;
   logic [IDX_BITS-1:0]   pal_raddr;

   // capture the request, with the row part of the cell address
   always_comb begin
      cmd_in      = cmd_ff;
      row_in      = row_ff;
      z_in        = z_ff;
      val_in      = val_ff;
      in_range_in = in_range_ff;
      if (cmd.capture) begin
         cmd_in      = req_command;
         row_in      = CELL_ABITS'(req_pos_x) * CELL_ABITS'(HEIGHT) + CELL_ABITS'(req_pos_y);
         z_in        = req_pos_z;
         val_in      = req_block_value[VW-1:0];
         in_range_in = (32'(req_pos_x) < 32'(SIDE)) && (32'(req_pos_y) < 32'(HEIGHT)) &&
                       (32'(req_pos_z) < 32'(SIDE));
      end
   end

   assign cell_addr = row_ff * CELL_ABITS'(SIDE) + CELL_ABITS'(z_ff);
   assign pal_full  = (count_ff == CNT_BITS'(PALETTE_DEPTH));

   // walk the palette one entry per cycle, compare each entry in the cycle after its read
   assign scan_rd = cmd.scan && (scan_ff < count_ff);

   always_comb begin
      scan_in     = scan_ff;
      rd_idx_in   = rd_idx_ff;
      found_in    = found_ff;
      hit_idx_in  = hit_idx_ff;
      rd_valid_in = scan_rd;
      if (cmd.scan_init) begin
         scan_in  = '0;
         found_in = 1'b0;
      end else if (scan_rd) begin
         scan_in   = scan_ff + CNT_BITS'(1);
         rd_idx_in = scan_ff[IDX_BITS-1:0];
      end
      if (cmd.scan && stat.scan_hit) begin
         found_in   = 1'b1;
         hit_idx_in = rd_idx_ff;
      end
   end

   // commit a write: reuse a hit, append a new value, or drop when full
   assign commit_new = cmd.commit && !found_ff && !pal_full;
   assign count_in   = commit_new ? count_ff + CNT_BITS'(1) : count_ff;
   assign clr_in     = cmd.clear ? clr_ff + CELL_ABITS'(1) : clr_ff;

   assign cell_we    = cmd.clear || (cmd.commit && (found_ff || !pal_full));
   assign cell_waddr = cmd.clear ? clr_ff : cell_addr;
   assign cell_wdata = cmd.clear ? '0 : (found_ff ? hit_idx_ff : count_ff[IDX_BITS-1:0]);

   assign pal_we    = (cmd.clear && clr_ff == '0) || commit_new;
   assign pal_waddr = cmd.clear ? '0 : count_ff[IDX_BITS-1:0];
   assign pal_wdata = cmd.clear ? '0 : val_ff;
   assign pal_re    = cmd.pal_rd_cell || scan_rd;
   assign pal_raddr = cmd.pal_rd_cell ? cell_q_ff : scan_ff[IDX_BITS-1:0];

   // build the response
   always_comb begin
      rsp_strobe_in = cmd.rsp_read || cmd.commit;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_used_in   = rsp_used_ff;
      if (cmd.rsp_read) begin
         rsp_value_in  = in_range_ff ? VALUE_FIELD_BITS'(pal_q_ff) : '0;
         rsp_status_in = STATUS_OK;
         rsp_used_in   = USED_BITS'(count_ff);
      end else if (cmd.commit) begin
         rsp_value_in  = '0;
         rsp_status_in = (!found_ff && pal_full) ? STATUS_FULL : STATUS_OK;
         rsp_used_in   = USED_BITS'(count_in);
      end
   end

   // cell index memory
   always_ff @(posedge clock) begin
      if (cell_we) cell_mem[cell_waddr] <= cell_wdata;
      if (cmd.cell_rd) cell_q_ff <= cell_mem[cell_addr];
   end

   // palette memory
   always_ff @(posedge clock) begin
      if (pal_we) pal_mem[pal_waddr] <= pal_wdata;
      if (pal_re) pal_q_ff <= pal_mem[pal_raddr];
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      row_ff        <= row_in;
      z_ff          <= z_in;
      val_ff        <= val_in;
      in_range_ff   <= in_range_in;
      scan_ff       <= scan_in;
      rd_idx_ff     <= rd_idx_in;
      found_ff      <= found_in;
      hit_idx_ff    <= hit_idx_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_used_ff   <= rsp_used_in;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= CNT_BITS'(1);
         clr_ff        <= '0;
         rd_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         clr_ff        <= clr_in;
         rd_valid_ff   <= rd_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   assign stat.clear_done = (clr_ff == CELL_ABITS'(CELL_COUNT - 1));
   assign stat.is_write   = (cmd_ff == CMD_WRITE);
   assign stat.in_range   = in_range_ff;
   assign stat.scan_hit   = rd_valid_ff && (pal_q_ff == val_ff);
   assign stat.scan_miss  = !rd_valid_ff && (scan_ff == count_ff);

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_read_value   = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_palette_used = rsp_used_ff;

`ifndef SYNTHESIS
   // palette occupancy stays within its bounds
   assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) && (count_ff <= CNT_BITS'(PALETTE_DEPTH)))
      else $error("palette count out of range");

   // palette grows by at most one entry per cycle
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (count_ff == $past(count_ff) ||
                         count_ff == $past(count_ff) + CNT_BITS'(1)))
      else $error("palette count jumped");

   // a dropped write is reported only with a full palette
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_status_ff == STATUS_FULL) |-> pal_full)
      else $error("full status with room in the palette");

   // a hit always points inside the used part of the palette
   assert property (@(posedge clock) disable iff (reset)
      found_ff |-> (CNT_BITS'(hit_idx_ff) < count_ff))
      else $error("palette hit beyond the used entries");
`endif

endmodule

>>> design/palette_voxel_store.sv
// A read passes through decode, the cell index read, the palette read and the
// registered response; a write through decode, a palette scan ending at the first
// hit or after all palette_used entries on a miss, and commit. Throughput: one
// request at a time; write time is set by the palette scan, which reads one entry
// per cycle through the palette memory's single read port. Responses cannot be
// stalled. Reset: synchronous; busy stays high while the cell store is cleared.
module palette_voxel_store
   import pvs_pkg::*;
#(
   parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF,
   parameter int VALUE_BITS    = VALUE_BITS_DEF,
   parameter int HEIGHT        = HEIGHT_DEF,
   parameter int SIDE          = SIDE_DEF
)
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_command,
   input  logic [X_BITS-1:0]           req_pos_x,
   input  logic [Y_BITS-1:0]           req_pos_y,
   input  logic [Z_BITS-1:0]           req_pos_z,
   input  logic [VALUE_FIELD_BITS-1:0] req_block_value,
   output logic                        rsp_strobe,
   output logic [VALUE_FIELD_BITS-1:0] rsp_read_value,
   output logic                        rsp_status,
   output logic [USED_BITS-1:0]        rsp_palette_used
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // sequence requests
   pvs_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // cell store, palette and response registers
   pvs_datapath #(
      .PALETTE_DEPTH (PALETTE_DEPTH),
      .VALUE_BITS    (VALUE_BITS),
      .HEIGHT        (HEIGHT),
      .SIDE          (SIDE)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_command      (req_command),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pos_z        (req_pos_z),
      .req_block_value  (req_block_value),
      .rsp_strobe       (rsp_strobe),
      .rsp_read_value   (rsp_read_value),
      .rsp_status       (rsp_status),
      .rsp_palette_used (rsp_palette_used)
   );

endmodule
